// ===== sv/cpio_pkg.sv =====
// Shared constants, types and lookup functions for the cpio newc header parser.
`default_nettype none

package cpio_pkg;

    localparam int unsigned HDR_LEN      = 110;
    localparam int unsigned NAME_CMP_LEN = 11;
    localparam int unsigned POS_MAX      = 121;
    localparam int unsigned FSIZE_START  = 54;
    localparam int unsigned NSIZE_START  = 94;
    localparam int unsigned HEX_DIGITS   = 8;
    localparam int unsigned MAGIC_LEN    = 6;

    localparam int unsigned POS_W  = 7;
    localparam int unsigned SIZE_W = 32;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_BAD_MAGIC = 2'd1,
        STATUS_SHORT     = 2'd2
    } status_t;

    typedef struct packed {
        logic       is_hex;
        logic [3:0] value;
    } hex_digit_t;

    function automatic hex_digit_t hex_decode(input logic [7:0] c);
        hex_digit_t d;
        d.is_hex = 1'b1;
        d.value  = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            d.value = 4'(c - 8'h30);
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            d.value = 4'(c - 8'h57);
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            d.value = 4'(c - 8'h37);
        end
        else
        begin
            d.is_hex = 1'b0;
        end
        return d;
    endfunction

    // "070701"
    function automatic logic [7:0] magic_byte(input logic [2:0] idx);
        logic [7:0] b;
        unique case (idx)
            3'd0:    b = 8'h30;
            3'd1:    b = 8'h37;
            3'd2:    b = 8'h30;
            3'd3:    b = 8'h37;
            3'd4:    b = 8'h30;
            3'd5:    b = 8'h31;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // "TRAILER!!!" and its terminating zero
    function automatic logic [7:0] trailer_byte(input logic [3:0] idx);
        logic [7:0] b;
        unique case (idx)
            4'd0:    b = 8'h54;
            4'd1:    b = 8'h52;
            4'd2:    b = 8'h41;
            4'd3:    b = 8'h49;
            4'd4:    b = 8'h4C;
            4'd5:    b = 8'h45;
            4'd6:    b = 8'h52;
            4'd7:    b = 8'h21;
            4'd8:    b = 8'h21;
            4'd9:    b = 8'h21;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic [SIZE_W-1:0] round4(input logic [SIZE_W-1:0] x);
        logic [SIZE_W-1:0] s;
        s = x + SIZE_W'(3);
        return {s[SIZE_W-1:2], 2'b00};
    endfunction

endpackage

`default_nettype wire

// ===== sv/cpio_stream_if.sv =====
// Handshake interfaces for the byte input channel and the result channel.
`default_nettype none

interface cpio_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;
    logic       last;

    modport source (output valid, output byte_in, output last, input ready);
    modport sink   (input valid, input byte_in, input last, output ready);
endinterface

interface cpio_out_if;
    logic                    valid;
    logic                    ready;
    cpio_pkg::status_t       status;
    logic [31:0]             file_size;
    logic [31:0]             name_size;
    logic [6:0]              name_offset;
    logic [31:0]             data_offset;
    logic [31:0]             next_offset;
    logic                    is_trailer;

    modport source (output valid, output status, output file_size, output name_size,
                    output name_offset, output data_offset, output next_offset,
                    output is_trailer, input ready);
    modport sink   (input valid, input status, input file_size, input name_size,
                    input name_offset, input data_offset, input next_offset,
                    input is_trailer, output ready);
endinterface

`default_nettype wire

// ===== sv/cpio_newc_header_parser.sv =====
// cpio newc header parser: byte-wise header scan with a three-stage result pipeline.
//
// in_ch carries one byte of a newc entry per word, header first, then the
// pathname; last marks the final byte of the entry. out_ch carries one
// result word per entry: status, parsed sizes, name/data/next offsets and
// the trailer flag.
// Throughput: one byte per cycle while in_ch.ready is high; entries may follow back to back.
// Each result passes through three register stages (summary, data offset add,
// next offset add) after the last byte is accepted, before out_ch.valid rises.
// Each byte updates the scan state in the cycle it is accepted; the last
// byte also returns the scan state to its reset values.
// Reset (rst_n low) clears the scan state and empties the pipeline.
// When out_ch stalls, the pipeline holds; in_ch.ready drops only once all
// three result stages are full.
`default_nettype none

module cpio_newc_header_parser (
    input  wire logic  clk,
    input  wire logic  rst_n,
    cpio_in_if.sink    in_ch,
    cpio_out_if.source out_ch
);
    import cpio_pkg::*;

    logic [POS_W-1:0]  pos_reg, pos_next;
    logic              magic_ok_reg, magic_ok_next;
    logic [SIZE_W-1:0] fs_acc_reg, fs_acc_next;
    logic              fs_stop_reg, fs_stop_next;
    logic [SIZE_W-1:0] ns_acc_reg, ns_acc_next;
    logic              ns_stop_reg, ns_stop_next;
    logic              tr_ok_reg, tr_ok_next;
    logic              tr_done_reg, tr_done_next;

    logic              s1_valid_reg;
    status_t           s1_status_reg;
    logic [SIZE_W-1:0] s1_fs_reg;
    logic [SIZE_W-1:0] s1_ns_reg;
    logic              s1_tr_reg;

    logic              s2_valid_reg;
    status_t           s2_status_reg;
    logic [SIZE_W-1:0] s2_fs_reg;
    logic [SIZE_W-1:0] s2_ns_reg;
    logic              s2_tr_reg;
    logic [SIZE_W-1:0] s2_data_reg;

    logic              out_valid_reg;
    status_t           out_status_reg;
    logic [SIZE_W-1:0] out_fs_reg;
    logic [SIZE_W-1:0] out_ns_reg;
    logic [POS_W-1:0]  out_name_off_reg;
    logic [SIZE_W-1:0] out_data_reg;
    logic [SIZE_W-1:0] out_next_reg;
    logic              out_tr_reg;

    logic              accept;
    logic              out_free, s2_free, s1_free;
    hex_digit_t        digit;
    logic [3:0]        name_idx;
    logic              in_magic, in_fsize, in_nsize, in_name;
    logic              short_hdr;
    status_t           fin_status;
    logic              fin_ok;

    assign out_free = !out_valid_reg || out_ch.ready;
    assign s2_free  = !s2_valid_reg || out_free;
    assign s1_free  = !s1_valid_reg || s2_free;

    assign in_ch.ready = s1_free;
    assign accept      = in_ch.valid && in_ch.ready;

    assign digit    = hex_decode(in_ch.byte_in);
    assign name_idx = 4'(pos_reg - POS_W'(HDR_LEN));

    assign in_magic = pos_reg < POS_W'(MAGIC_LEN);
    assign in_fsize = pos_reg >= POS_W'(FSIZE_START)
                   && pos_reg < POS_W'(FSIZE_START + HEX_DIGITS);
    assign in_nsize = pos_reg >= POS_W'(NSIZE_START)
                   && pos_reg < POS_W'(NSIZE_START + HEX_DIGITS);
    assign in_name  = pos_reg >= POS_W'(HDR_LEN)
                   && pos_reg < POS_W'(HDR_LEN + NAME_CMP_LEN);

    // fewer than HDR_LEN bytes once this one is counted
    assign short_hdr = pos_reg < POS_W'(HDR_LEN - 1);

    always_comb
    begin
        magic_ok_next = magic_ok_reg;
        fs_acc_next   = fs_acc_reg;
        fs_stop_next  = fs_stop_reg;
        ns_acc_next   = ns_acc_reg;
        ns_stop_next  = ns_stop_reg;
        tr_ok_next    = tr_ok_reg;
        tr_done_next  = tr_done_reg;
        pos_next      = (pos_reg < POS_W'(POS_MAX)) ? pos_reg + POS_W'(1) : POS_W'(POS_MAX);

        if (in_magic)
        begin
            if (in_ch.byte_in != magic_byte(pos_reg[2:0]))
            begin
                magic_ok_next = 1'b0;
            end
        end
        else if (in_fsize)
        begin
            if (!fs_stop_reg)
            begin
                if (digit.is_hex)
                begin
                    fs_acc_next = {fs_acc_reg[SIZE_W-5:0], digit.value};
                end
                else
                begin
                    fs_stop_next = 1'b1;
                end
            end
        end
        else if (in_nsize)
        begin
            if (!ns_stop_reg)
            begin
                if (digit.is_hex)
                begin
                    ns_acc_next = {ns_acc_reg[SIZE_W-5:0], digit.value};
                end
                else
                begin
                    ns_stop_next = 1'b1;
                end
            end
        end
        else if (in_name)
        begin
            if (in_ch.byte_in != trailer_byte(name_idx))
            begin
                tr_ok_next = 1'b0;
            end
            if (name_idx == 4'(NAME_CMP_LEN - 1))
            begin
                tr_done_next = 1'b1;
            end
        end
    end

    always_comb
    begin
        priority if (short_hdr)
        begin
            fin_status = STATUS_SHORT;
        end
        else if (!magic_ok_next)
        begin
            fin_status = STATUS_BAD_MAGIC;
        end
        else
        begin
            fin_status = STATUS_OK;
        end
    end

    assign fin_ok = (fin_status == STATUS_OK);

    // scan state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            magic_ok_reg <= 1'b1;
            fs_acc_reg   <= '0;
            fs_stop_reg  <= 1'b0;
            ns_acc_reg   <= '0;
            ns_stop_reg  <= 1'b0;
            tr_ok_reg    <= 1'b1;
            tr_done_reg  <= 1'b0;
        end
        else if (accept)
        begin
            if (in_ch.last)
            begin
                pos_reg      <= '0;
                magic_ok_reg <= 1'b1;
                fs_acc_reg   <= '0;
                fs_stop_reg  <= 1'b0;
                ns_acc_reg   <= '0;
                ns_stop_reg  <= 1'b0;
                tr_ok_reg    <= 1'b1;
                tr_done_reg  <= 1'b0;
            end
            else
            begin
                pos_reg      <= pos_next;
                magic_ok_reg <= magic_ok_next;
                fs_acc_reg   <= fs_acc_next;
                fs_stop_reg  <= fs_stop_next;
                ns_acc_reg   <= ns_acc_next;
                ns_stop_reg  <= ns_stop_next;
                tr_ok_reg    <= tr_ok_next;
                tr_done_reg  <= tr_done_next;
            end
        end
    end

    // stage 1: entry summary
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_free)
        begin
            s1_valid_reg <= accept && in_ch.last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && in_ch.last)
        begin
            s1_status_reg <= fin_status;
            s1_fs_reg     <= fin_ok ? fs_acc_next : '0;
            s1_ns_reg     <= fin_ok ? ns_acc_next : '0;
            s1_tr_reg     <= fin_ok && tr_ok_next && tr_done_next;
        end
    end

    // stage 2: data offset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_free)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_free && s1_valid_reg)
        begin
            s2_status_reg <= s1_status_reg;
            s2_fs_reg     <= s1_fs_reg;
            s2_ns_reg     <= s1_ns_reg;
            s2_tr_reg     <= s1_tr_reg;
            s2_data_reg   <= (s1_status_reg == STATUS_OK)
                           ? round4(s1_ns_reg + SIZE_W'(HDR_LEN)) : '0;
        end
    end

    // stage 3: next offset, output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && s2_valid_reg)
        begin
            out_status_reg   <= s2_status_reg;
            out_fs_reg       <= s2_fs_reg;
            out_ns_reg       <= s2_ns_reg;
            out_name_off_reg <= (s2_status_reg == STATUS_OK) ? POS_W'(HDR_LEN) : '0;
            out_data_reg     <= s2_data_reg;
            out_next_reg     <= s2_tr_reg ? '0 : s2_data_reg + round4(s2_fs_reg);
            out_tr_reg       <= s2_tr_reg;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.status      = out_status_reg;
    assign out_ch.file_size   = out_fs_reg;
    assign out_ch.name_size   = out_ns_reg;
    assign out_ch.name_offset = out_name_off_reg;
    assign out_ch.data_offset = out_data_reg;
    assign out_ch.next_offset = out_next_reg;
    assign out_ch.is_trailer  = out_tr_reg;

    a_scan_clears_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        accept && in_ch.last |=> pos_reg == '0 && magic_ok_reg && !fs_stop_reg)
        else $error("scan state not cleared after last word");

    a_pos_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_W'(POS_MAX))
        else $error("byte position beyond saturation");

    a_bad_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_status_reg != STATUS_OK |->
            out_fs_reg == '0 && out_ns_reg == '0 && out_data_reg == '0
            && out_next_reg == '0 && !out_tr_reg && out_name_off_reg == '0)
        else $error("failed entry reports nonzero fields");

    a_trailer_next_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_tr_reg |-> out_next_reg == '0)
        else $error("trailer with nonzero next offset");

    a_pipe_fill_order: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ch.ready |-> s1_valid_reg && s2_valid_reg && out_valid_reg)
        else $error("input stalled with a free result stage");

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the cpio newc header parser: directed entries, then random streams.
`default_nettype none

module testbench;

    import cpio_pkg::*;

    localparam logic [47:0] MAGIC_TEXT   = "070701";
    localparam logic [87:0] TRAILER_NAME = {"TRAILER!!!", 8'h00};
    localparam int          HEADER_BYTES = 110;
    localparam int          NAME_END     = 121;
    localparam int          FSZ_FIRST    = 54;
    localparam int          NSZ_FIRST    = 94;
    localparam int          LONG_HOLD    = 300;

    typedef struct packed {
        status_t     status;
        logic [31:0] file_size;
        logic [31:0] name_size;
        logic [6:0]  name_offset;
        logic [31:0] data_offset;
        logic [31:0] next_offset;
        logic        is_trailer;
    } entry_result_t;

    typedef struct packed {
        logic [47:0]   magic;
        logic [63:0]   fsz_digits;
        logic [63:0]   nsz_digits;
        logic [87:0]   name;
        logic [7:0]    len;
        logic          typed;
        entry_result_t want;
    } entry_row_t;

    logic clk;
    logic rst_n;

    cpio_in_if  in_ch ();
    cpio_out_if out_ch ();

    cpio_newc_header_parser u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    entry_result_t pending_results [$];
    int            mismatch_count = 0;
    int            stream_bytes = 0;
    bit            quiet = 0;
    bit            long_hold = 0;

    // header scan state
    logic [6:0]  scan_pos;
    logic        magic_ok;
    logic [31:0] fsz_acc;
    logic        fsz_done;
    logic [31:0] nsz_acc;
    logic        nsz_done;
    logic        name_ok;
    logic        name_done;

    entry_row_t directed_rows [12] = '{
        '{"070701", "00000000", "00000000", 88'h0, 8'd1, 1'b1,
          '{STATUS_SHORT, 32'd0, 32'd0, 7'd0, 32'd0, 32'd0, 1'b0}},
        '{"070701", "00000000", "00000000", 88'h0, 8'd109, 1'b1,
          '{STATUS_SHORT, 32'd0, 32'd0, 7'd0, 32'd0, 32'd0, 1'b0}},
        '{"X70701", "00000000", "00000000", 88'h0, 8'd50, 1'b1,
          '{STATUS_SHORT, 32'd0, 32'd0, 7'd0, 32'd0, 32'd0, 1'b0}},
        '{"070702", "00000000", "00000000", 88'h0, 8'd110, 1'b1,
          '{STATUS_BAD_MAGIC, 32'd0, 32'd0, 7'd0, 32'd0, 32'd0, 1'b0}},
        '{"070701", "00000000", "0000000B", {"TRAILER!!!", 8'h00}, 8'd121, 1'b1,
          '{STATUS_OK, 32'd0, 32'd11, 7'd110, 32'd124, 32'd0, 1'b1}},
        '{"070701", "FFFFFFFF", "FFFFFFFF", 88'h0, 8'd110, 1'b0, '0},
        '{"070701", "00000010", "00000006", {"TRAIL", 48'h0}, 8'd115, 1'b0, '0},
        '{"070701", "0000abcd", "0000000b", {"TRAILER!!!", 8'h00}, 8'd200, 1'b0, '0},
        '{"070701", "12G45678", "abcDEF01", {"name_a.txt", 8'h00}, 8'd121, 1'b0, '0},
        '{"070701", "Z0000000", "00000010", {"TRAILER!!!", "X"}, 8'd125, 1'b0, '0},
        '{"070701", "7fffffff", "00000003", {"TRAILER!!?", 8'h00}, 8'd121, 1'b0, '0},
        '{"070701", "00000003", "00000001", {"a", 80'h0}, 8'd111, 1'b0, '0}
    };

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #8000000;
        $display("testbench failed");
        $finish;
    end

    function automatic int hex_digit_value(input logic [7:0] c);
        if (c >= "0" && c <= "9")
            return int'(c - "0");
        if (c >= "a" && c <= "f")
            return int'(c - "a") + 10;
        if (c >= "A" && c <= "F")
            return int'(c - "A") + 10;
        return -1;
    endfunction

    function automatic logic [31:0] round_up4(input logic [31:0] x);
        return (x + 32'd3) & ~32'd3;
    endfunction

    task automatic clear_scan();
        scan_pos  = '0;
        magic_ok  = 1'b1;
        fsz_acc   = '0;
        fsz_done  = 1'b0;
        nsz_acc   = '0;
        nsz_done  = 1'b0;
        name_ok   = 1'b1;
        name_done = 1'b0;
    endtask

    task automatic scan_byte(input logic [7:0] b, input logic lst, output logic done,
                             output entry_result_t r);
        int          p;
        int          d;
        logic [31:0] data_off;
        p = int'(scan_pos);
        done = 1'b0;
        r = '0;
        if (p < 6)
        begin
            if (b != MAGIC_TEXT[47-8*p -: 8])
                magic_ok = 1'b0;
        end
        else if (p >= FSZ_FIRST && p < FSZ_FIRST + 8)
        begin
            if (!fsz_done)
            begin
                d = hex_digit_value(b);
                if (d < 0)
                    fsz_done = 1'b1;
                else
                    fsz_acc = {fsz_acc[27:0], 4'(d)};
            end
        end
        else if (p >= NSZ_FIRST && p < NSZ_FIRST + 8)
        begin
            if (!nsz_done)
            begin
                d = hex_digit_value(b);
                if (d < 0)
                    nsz_done = 1'b1;
                else
                    nsz_acc = {nsz_acc[27:0], 4'(d)};
            end
        end
        else if (p >= HEADER_BYTES && p < NAME_END)
        begin
            if (b != TRAILER_NAME[87-8*(p-HEADER_BYTES) -: 8])
                name_ok = 1'b0;
            if (p == NAME_END - 1)
                name_done = 1'b1;
        end
        if (p < NAME_END)
            scan_pos = scan_pos + 7'd1;
        if (lst)
        begin
            done = 1'b1;
            if (p + 1 < HEADER_BYTES)
                r.status = STATUS_SHORT;
            else if (!magic_ok)
                r.status = STATUS_BAD_MAGIC;
            else
            begin
                data_off      = round_up4(nsz_acc + 32'd110);
                r.status      = STATUS_OK;
                r.file_size   = fsz_acc;
                r.name_size   = nsz_acc;
                r.name_offset = 7'd110;
                r.data_offset = data_off;
                r.is_trailer  = name_ok && name_done;
                r.next_offset = r.is_trailer ? 32'd0 : data_off + round_up4(fsz_acc);
            end
            clear_scan();
        end
    endtask

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("MISMATCH %s: got 0x%08h, expected 0x%08h at %0t", what, got, want, $time);
        mismatch_count++;
    endtask

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_byte(input logic [7:0] b, input logic lst, input entry_row_t row);
        logic          done;
        entry_result_t r;
        if (!quiet && !long_hold && $urandom_range(0, 9) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.byte_in <= b;
        in_ch.last    <= lst;
        @(posedge clk);
        while (in_ch.ready !== 1'b1)
            @(posedge clk);
        scan_byte(b, lst, done, r);
        if (done)
            pending_results.push_back(row.typed ? row.want : r);
        stream_bytes++;
        @(negedge clk);
    endtask

    task automatic send_entry(input entry_row_t row, input bit rnd_fill);
        int         i;
        logic [7:0] b;
        for (i = 0; i < int'(row.len); i++)
        begin
            if (i < 6)
                b = row.magic[47-8*i -: 8];
            else if (i >= FSZ_FIRST && i < FSZ_FIRST + 8)
                b = row.fsz_digits[63-8*(i-FSZ_FIRST) -: 8];
            else if (i >= NSZ_FIRST && i < NSZ_FIRST + 8)
                b = row.nsz_digits[63-8*(i-NSZ_FIRST) -: 8];
            else if (i >= HEADER_BYTES && i < NAME_END)
                b = row.name[87-8*(i-HEADER_BYTES) -: 8];
            else if (rnd_fill)
                b = 8'($urandom);
            else
                b = (i < HEADER_BYTES) ? "0" : "x";
            send_byte(b, i == int'(row.len) - 1, row);
        end
    endtask

    function automatic logic [63:0] random_digits();
        string       hex_chars;
        logic [63:0] s;
        int          i;
        hex_chars = "0123456789abcdefABCDEF";
        for (i = 0; i < 8; i++)
        begin
            if ($urandom_range(0, 24) == 0)
                s[8*i +: 8] = 8'($urandom);
            else
                s[8*i +: 8] = hex_chars[$urandom_range(0, 21)];
        end
        return s;
    endfunction

    task automatic random_entry(input bit tiny);
        entry_row_t row;
        int         k;
        row = '0;
        row.magic = MAGIC_TEXT;
        if ($urandom_range(0, 9) == 0)
        begin
            k = $urandom_range(0, 5);
            row.magic[8*k +: 8] = 8'($urandom);
        end
        row.fsz_digits = random_digits();
        row.nsz_digits = random_digits();
        if ($urandom_range(0, 1) == 1)
        begin
            row.name = TRAILER_NAME;
            if ($urandom_range(0, 2) == 0)
            begin
                k = $urandom_range(0, 10);
                row.name[8*k +: 8] = 8'($urandom);
            end
        end
        else
            row.name = 88'({$urandom, $urandom, $urandom});
        k = $urandom_range(0, 19);
        if (tiny)
            row.len = 8'($urandom_range(1, 8));
        else if (k < 3)
            row.len = 8'($urandom_range(1, 109));
        else if (k < 6)
            row.len = 8'($urandom_range(110, 120));
        else if (k < 17)
            row.len = 8'($urandom_range(121, 124));
        else
            row.len = 8'($urandom_range(125, 200));
        send_entry(row, 1'b1);
    endtask

    // result receiver
    initial
    begin
        out_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (long_hold)
            begin
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                long_hold = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(negedge clk);
            end
            out_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        entry_result_t want;
        if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        begin
            if (pending_results.size() == 0)
                report("unexpected result word", 32'(out_ch.status), 32'hffff_ffff);
            else
            begin
                want = pending_results.pop_front();
                if (out_ch.status !== want.status)
                    report("status", 32'(out_ch.status), 32'(want.status));
                if (out_ch.file_size !== want.file_size)
                    report("file_size", out_ch.file_size, want.file_size);
                if (out_ch.name_size !== want.name_size)
                    report("name_size", out_ch.name_size, want.name_size);
                if (out_ch.name_offset !== want.name_offset)
                    report("name_offset", 32'(out_ch.name_offset), 32'(want.name_offset));
                if (out_ch.data_offset !== want.data_offset)
                    report("data_offset", out_ch.data_offset, want.data_offset);
                if (out_ch.next_offset !== want.next_offset)
                    report("next_offset", out_ch.next_offset, want.next_offset);
                if (out_ch.is_trailer !== want.is_trailer)
                    report("is_trailer", 32'(out_ch.is_trailer), 32'(want.is_trailer));
            end
        end
    end

    initial
    begin
        int entries;
        rst_n         = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.byte_in = 8'h00;
        in_ch.last    = 1'b0;
        clear_scan();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            send_entry(directed_rows[i], 1'b0);

        entries = 0;
        while (stream_bytes < 1400 || entries < 1)
        begin
            if (entries == 0)
            begin
                // stall the output while short entries keep coming
                long_hold = 1'b1;
                repeat (6) random_entry(1'b1);
            end
            random_entry(1'b0);
            entries++;
        end

        quiet = 1'b1;
        repeat (5) random_entry(1'b0);
        in_ch.valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

`default_nettype wire
